@@ rtl/pair_distance_capacity_unit_defines.svh @@
// Assertion macros shared by the pair distance capacity RTL
`ifndef PAIR_DISTANCE_CAPACITY_UNIT_DEFINES_SVH
`define PAIR_DISTANCE_CAPACITY_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define PDC_ASSERT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked outside reset
`define PDC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/pdc_pkg.sv @@
// Shared constants and types for the pair distance capacity unit
`default_nettype none
package pdc_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int LIMIT_W        = 17;
    localparam int CAP_W          = 17;
    localparam int FRAC_BITS      = 16;
    localparam int CFG_IDX_W      = 1;

    localparam logic [LIMIT_W-1:0]   NEAR_RESET = 17'h00000;
    localparam logic [LIMIT_W-1:0]   FAR_RESET  = 17'h1FFFF;
    localparam logic [CAP_W-1:0]     CAP_ONE    = 17'h10000;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR    = 1'b1;

    typedef struct packed {
        logic too_far;
        logic full;
        logic flat;
    } pdc_flags_t;
endpackage
`default_nettype wire

@@ rtl/pdc_dist.sv @@
// Pipelined floored Euclidean distance between two 3D points
`default_nettype none
module pdc_dist #(
    parameter int COORD_BITS = pdc_pkg::COORD_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           ce,
    input  wire logic                           in_valid,
    input  wire logic [5:0][COORD_BITS-1:0]     coords,   // a x,y,z then b x,y,z
    output logic                                out_valid,
    output logic [COORD_BITS+1:0]               distance
);
    localparam int CW   = COORD_BITS;
    localparam int DW   = CW + 1;
    localparam int SQW  = 2 * DW;
    localparam int RW   = CW + 2;
    localparam int NW   = 2 * RW;
    localparam int REMW = RW + 3;

    logic [DW-1:0]   abs_reg  [3];
    logic [DW-1:0]   abs_next [3];
    logic [SQW-1:0]  sq_reg   [3];
    logic [NW-1:0]   sum_reg;
    logic [2:0]      front_v_reg;

    logic [REMW-1:0] rem_reg   [RW];
    logic [REMW-1:0] rem_next  [RW];
    logic [RW-1:0]   root_reg  [RW];
    logic [RW-1:0]   root_next [RW];
    logic [NW-1:0]   rad_reg   [RW];
    logic [NW-1:0]   rad_next  [RW];
    logic [RW-1:0]   sv_reg;

    always_comb
    begin
        logic signed [DW-1:0] diff;
        for (int j = 0; j < 3; j++)
        begin
            diff = $signed({coords[j][CW-1], coords[j]})
                 - $signed({coords[j+3][CW-1], coords[j+3]});
            abs_next[j] = diff[DW-1] ? DW'(-diff) : DW'(diff);
        end
    end

    // one root bit per stage, two radicand bits consumed each time
    always_comb
    begin
        logic [REMW-1:0] rem_in;
        logic [RW-1:0]   root_in;
        logic [NW-1:0]   rad_in;
        logic [REMW-1:0] shifted;
        logic [REMW-1:0] trial;
        for (int k = 0; k < RW; k++)
        begin
            if (k == 0)
            begin
                rem_in  = '0;
                root_in = '0;
                rad_in  = sum_reg;
            end
            else
            begin
                rem_in  = rem_reg[k-1];
                root_in = root_reg[k-1];
                rad_in  = rad_reg[k-1];
            end
            shifted = {rem_in[REMW-3:0], rad_in[NW-1:NW-2]};
            trial   = {1'b0, root_in, 2'b01};
            if (shifted >= trial)
            begin
                rem_next[k]  = shifted - trial;
                root_next[k] = {root_in[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = shifted;
                root_next[k] = {root_in[RW-2:0], 1'b0};
            end
            rad_next[k] = {rad_in[NW-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int j = 0; j < 3; j++)
            begin
                abs_reg[j] <= abs_next[j];
                sq_reg[j]  <= SQW'(abs_reg[j]) * SQW'(abs_reg[j]);
            end
            sum_reg <= NW'(sq_reg[0]) + NW'(sq_reg[1]) + NW'(sq_reg[2]);
            for (int k = 0; k < RW; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= rad_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_v_reg <= '0;
            sv_reg      <= '0;
        end
        else if (ce)
        begin
            front_v_reg <= {front_v_reg[1:0], in_valid};
            sv_reg      <= {sv_reg[RW-2:0], front_v_reg[2]};
        end
    end

    assign out_valid = sv_reg[RW-1];
    assign distance  = root_reg[RW-1];
endmodule
`default_nettype wire

@@ rtl/pdc_div.sv @@
// Pipelined restoring divider: floor(num * 2^16 / den) for num <= den
`default_nettype none
module pdc_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              ce,
    input  wire logic                              in_valid,
    input  wire logic [pdc_pkg::LIMIT_W-1:0]       num,
    input  wire logic [pdc_pkg::LIMIT_W-1:0]       den,
    input  wire pdc_pkg::pdc_flags_t               in_flags,
    output logic                                   out_valid,
    output logic [pdc_pkg::CAP_W-1:0]              quot,
    output pdc_pkg::pdc_flags_t                    out_flags
);
    import pdc_pkg::*;

    localparam int ST = FRAC_BITS + 1;

    logic [LIMIT_W-1:0] rem_reg   [ST];
    logic [LIMIT_W-1:0] rem_next  [ST];
    logic [CAP_W-1:0]   q_reg     [ST];
    logic [CAP_W-1:0]   q_next    [ST];
    logic [LIMIT_W-1:0] den_reg   [ST];
    logic [LIMIT_W-1:0] den_next  [ST];
    pdc_flags_t         fl_reg    [ST];
    pdc_flags_t         fl_next   [ST];
    logic [ST-1:0]      v_reg;

    // remainder stays below den, so a one-bit left shift fits LIMIT_W+1
    always_comb
    begin
        logic [LIMIT_W:0]   shifted;
        logic [LIMIT_W-1:0] d_in;
        logic [CAP_W-1:0]   q_in;
        logic               ge;
        for (int k = 0; k < ST; k++)
        begin
            if (k == 0)
            begin
                shifted    = {1'b0, num};
                d_in       = den;
                q_in       = '0;
                fl_next[k] = in_flags;
            end
            else
            begin
                shifted    = {rem_reg[k-1], 1'b0};
                d_in       = den_reg[k-1];
                q_in       = q_reg[k-1];
                fl_next[k] = fl_reg[k-1];
            end
            ge          = shifted >= {1'b0, d_in};
            rem_next[k] = ge ? LIMIT_W'(shifted - {1'b0, d_in}) : LIMIT_W'(shifted);
            q_next[k]   = {q_in[CAP_W-2:0], ge};
            den_next[k] = d_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int k = 0; k < ST; k++)
            begin
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
                den_reg[k] <= den_next[k];
                fl_reg[k]  <= fl_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (ce)
        begin
            v_reg <= {v_reg[ST-2:0], in_valid};
        end
    end

    assign out_valid = v_reg[ST-1];
    assign quot      = q_reg[ST-1];
    assign out_flags = fl_reg[ST-1];
endmodule
`default_nettype wire

@@ rtl/pair_distance_capacity_unit.sv @@
// Pair distance capacity: top level with limits, compare stage and output register
//
// Takes one pair of points seen in two frames per transfer and returns one
// capacity per transfer. Fully pipelined: one transfer per cycle in and out
// through the square-root stages (one root bit each), 17 divider stages (one
// quotient bit each) and the difference, square, sum, compare and output
// registers. The whole pipeline holds while the output transfer is stalled.
// Limits are written through cfg_we/cfg_index/cfg_data and must only change
// while idle.
`default_nettype none
`include "pair_distance_capacity_unit_defines.svh"
module pair_distance_capacity_unit #(
    parameter int COORD_BITS = pdc_pkg::COORD_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // first_a_x, first_a_y, first_a_z, first_b_x, first_b_y, first_b_z,
    // second_a_x, second_a_y, second_a_z, second_b_x, second_b_y, second_b_z
    input  wire logic [((12*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // capacity[16:0], too_far[17], zero fill
    output logic [23:0]                             m_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic                               cfg_we,
    input  wire logic [pdc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pdc_pkg::LIMIT_W-1:0]        cfg_data
);
    import pdc_pkg::*;

    localparam int DIST_W = COORD_BITS + 2;
    localparam int CMP_W  = (DIST_W > LIMIT_W) ? DIST_W : LIMIT_W;

    logic [LIMIT_W-1:0] near_reg;
    logic [LIMIT_W-1:0] far_reg;
    logic               ce;

    logic                 va;
    logic                 vb;
    logic [DIST_W-1:0]    da;
    logic [DIST_W-1:0]    db;

    logic [LIMIT_W-1:0]   num_reg;
    logic [LIMIT_W-1:0]   den_reg;
    pdc_flags_t           cmp_fl_reg;
    logic                 cmp_v_reg;
    pdc_flags_t           cmp_fl_next;
    logic [CMP_W-1:0]     d_max;
    logic [CMP_W-1:0]     near_x;
    logic [CMP_W-1:0]     far_x;

    logic                 dv_valid;
    logic [CAP_W-1:0]     dv_quot;
    pdc_flags_t           dv_flags;

    logic [CAP_W-1:0]     cap_reg;
    logic [CAP_W-1:0]     cap_next;
    logic                 too_far_reg;
    logic                 out_v_reg;

    assign ce            = m_axis_tready || !out_v_reg;
    assign s_axis_tready = ce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg <= NEAR_RESET;
            far_reg  <= FAR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NEAR: near_reg <= cfg_data;
                CFG_FAR:  far_reg  <= cfg_data;
                default:  ;
            endcase
        end
    end

    pdc_dist #(.COORD_BITS(COORD_BITS)) u_dist_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (s_axis_tvalid),
        .coords    (s_axis_tdata[6*COORD_BITS-1:0]),
        .out_valid (va),
        .distance  (da)
    );

    pdc_dist #(.COORD_BITS(COORD_BITS)) u_dist_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (s_axis_tvalid),
        .coords    (s_axis_tdata[12*COORD_BITS-1:6*COORD_BITS]),
        .out_valid (vb),
        .distance  (db)
    );

    // numerator and denominator only matter on the sloped branch
    always_comb
    begin
        logic [CMP_W-1:0] da_x;
        logic [CMP_W-1:0] db_x;
        da_x   = CMP_W'(da);
        db_x   = CMP_W'(db);
        near_x = CMP_W'(near_reg);
        far_x  = CMP_W'(far_reg);
        d_max  = (da_x >= db_x) ? da_x : db_x;
        cmp_fl_next.too_far = (da_x > far_x) || (db_x > far_x);
        cmp_fl_next.full    = d_max < near_x;
        cmp_fl_next.flat    = far_reg == near_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            num_reg    <= LIMIT_W'(far_x - d_max);
            den_reg    <= far_reg - near_reg;
            cmp_fl_reg <= cmp_fl_next;
            cap_reg    <= cap_next;
            too_far_reg <= dv_flags.too_far;
        end
    end

    pdc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (cmp_v_reg),
        .num       (num_reg),
        .den       (den_reg),
        .in_flags  (cmp_fl_reg),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .out_flags (dv_flags)
    );

    always_comb
    begin
        if (dv_flags.too_far)
            cap_next = '0;
        else if (dv_flags.full)
            cap_next = CAP_ONE;
        else if (dv_flags.flat)
            cap_next = '0;
        else
            cap_next = dv_quot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (ce)
        begin
            cmp_v_reg <= va;
            out_v_reg <= dv_valid;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {6'b0, too_far_reg, cap_reg};

    `PDC_ASSERT(a_far_zero, m_axis_tvalid && too_far_reg, cap_reg == '0, "too_far with nonzero capacity")
    `PDC_ASSERT(a_cap_range, m_axis_tvalid, cap_reg <= CAP_ONE, "capacity above 1.0")
    `PDC_ASSERT_NEXT(a_full, ce && dv_valid && dv_flags.full && !dv_flags.too_far, cap_reg == CAP_ONE, "full capacity lost")
    `PDC_ASSERT(a_dist_sync, 1'b1, va == vb, "distance units out of step")
endmodule
`default_nettype wire
